// ----- sv/midi_byte_stream_parser_unit_assert.svh -----
// ----------------------------------------------------------------------------
// midi byte stream parser assertion macros
// shared concurrent assertion forms, clocked on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef MIDI_BYTE_STREAM_PARSER_UNIT_ASSERT_SVH
`define MIDI_BYTE_STREAM_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define MBSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MBSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mbsp_pkg.sv -----
// ----------------------------------------------------------------------------
// mbsp_pkg
// types and codes shared by the midi byte stream parser
// ----------------------------------------------------------------------------
package mbsp_pkg;

    localparam int BYTE_W = 8;
    localparam int DATA_W = 7;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [DATA_W-1:0] data_t;
    typedef logic [1:0]        count_t;

    // byte class codes
    typedef logic [2:0] kind_t;
    localparam kind_t KIND_DATA       = 3'd0;
    localparam kind_t KIND_RT_FWD     = 3'd1;
    localparam kind_t KIND_RT_DROP    = 3'd2;
    localparam kind_t KIND_SYX_START  = 3'd3;
    localparam kind_t KIND_SYX_END    = 3'd4;
    localparam kind_t KIND_SYS_COMMON = 3'd5;
    localparam kind_t KIND_CHAN       = 3'd6;

    localparam byte_t STATUS_NONE = 8'h00;

    typedef struct packed {
        kind_t  kind;
        byte_t  value;
        count_t need;
    } qent_t;

endpackage

// ----- sv/mbsp_ifs.sv -----
// ----------------------------------------------------------------------------
// mbsp channel interfaces
// valid/ready channels for raw midi bytes and parsed messages
// ----------------------------------------------------------------------------
interface mbsp_in_if;
    import mbsp_pkg::*;

    logic  valid;
    logic  ready;
    byte_t midi_byte;

    modport source (output valid, output midi_byte, input ready);
    modport sink (input valid, input midi_byte, output ready);
endinterface

interface mbsp_out_if;
    import mbsp_pkg::*;

    logic  valid;
    logic  ready;
    byte_t msg_status;
    data_t msg_data1;
    data_t msg_data2;

    modport source (output valid, output msg_status, output msg_data1,
                    output msg_data2, input ready);
    modport sink (input valid, input msg_status, input msg_data1,
                  input msg_data2, output ready);
endinterface

// ----- sv/midi_byte_stream_parser_unit.sv -----
// ----------------------------------------------------------------------------
// midi_byte_stream_parser_unit
// raw midi byte stream in, complete channel and real-time messages out
// ----------------------------------------------------------------------------
// byte_in carries one raw midi byte per request; msg_out carries one parsed
// message per request (status byte plus two 7-bit data bytes, zero-filled).
// a byte enters a classifier, waits in a QUEUE_DEPTH-entry request queue and
// is then applied to the running status engine, which owns one result
// register. a completing byte is registered in the queue, and the engine
// loads its message into the result register as it pops that byte. the
// engine takes one byte per cycle while the queue holds bytes and a
// completing byte finds the result register free; dropped real-time bytes
// never enter the queue. when msg_out stalls, the engine keeps applying
// bytes that make no message; a byte that completes a message waits in
// the queue, and byte_in drops ready once the queue is full.
// reset clears running status, sysex state, the queue and the valid flag of
// the result register; no message is pending after reset.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser_unit
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    mbsp_in_if.sink    byte_in,
    mbsp_out_if.source msg_out
);
    import mbsp_pkg::*;

    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    qent_t q_wdata;
    qent_t q_rdata;

    mbsp_front u_front
    (
        .byte_in (byte_in),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_wdata)
    );

    mbsp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    mbsp_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .msg_out (msg_out)
    );

endmodule

// ----- sv/mbsp_front.sv -----
// ----------------------------------------------------------------------------
// mbsp_front
// accepts raw bytes, classifies them and pushes them into the queue
// ----------------------------------------------------------------------------
module mbsp_front
(
    mbsp_in_if.sink        byte_in,
    input  logic           q_full,
    output logic           q_push,
    output mbsp_pkg::qent_t q_data
);
    import mbsp_pkg::*;

    kind_t  kind;
    count_t need;

    always_comb
    begin
        if (!byte_in.midi_byte[7])
        begin
            kind = KIND_DATA;
        end
        else
        begin
            case (byte_in.midi_byte) inside
                8'hF8, 8'hFA, 8'hFB, 8'hFC: kind = KIND_RT_FWD;
                8'hF9, 8'hFD, 8'hFE, 8'hFF: kind = KIND_RT_DROP;
                8'hF0:                      kind = KIND_SYX_START;
                8'hF7:                      kind = KIND_SYX_END;
                [8'hF1:8'hF6]:              kind = KIND_SYS_COMMON;
                default:                    kind = KIND_CHAN;
            endcase
        end
    end

    always_comb
    begin
        case (byte_in.midi_byte[7:4]) inside
            4'hC, 4'hD: need = 2'd1;
            default:    need = 2'd2;
        endcase
    end

    assign byte_in.ready = !q_full;
    // dropped real-time bytes touch nothing, so they never enter the queue
    assign q_push        = byte_in.valid && !q_full && (kind != KIND_RT_DROP);
    assign q_data        = '{kind: kind, value: byte_in.midi_byte, need: need};

endmodule

// ----- sv/mbsp_fifo.sv -----
// ----------------------------------------------------------------------------
// mbsp_fifo
// short request queue between the classifier and the message builder
// ----------------------------------------------------------------------------
`include "midi_byte_stream_parser_unit_assert.svh"

module mbsp_fifo
#(
    parameter int DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mbsp_pkg::qent_t push_data,
    output logic            full,
    input  logic            pop,
    output mbsp_pkg::qent_t pop_data,
    output logic            empty
);
    import mbsp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qent_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    `MBSP_ASSERT_NOW(a_fifo_no_overfill, 1'b1, count_reg <= CNT_W'(DEPTH), "queue overfilled")
    `MBSP_ASSERT_NOW(a_fifo_pop_nonempty, pop, !empty, "pop from empty queue")

endmodule

// ----- sv/mbsp_back.sv -----
// ----------------------------------------------------------------------------
// mbsp_back
// running status engine: builds messages and holds the result register
// ----------------------------------------------------------------------------
`include "midi_byte_stream_parser_unit_assert.svh"

module mbsp_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  mbsp_pkg::qent_t q_data,
    output logic            q_pop,
    mbsp_out_if.source      msg_out
);
    import mbsp_pkg::*;

    byte_t  rs_reg, rs_next;
    data_t  first_reg, first_next;
    count_t have_reg, have_next;
    count_t need_reg, need_next;
    logic   sysex_reg, sysex_next;

    logic   out_valid_reg, out_valid_next;
    byte_t  out_status_reg, out_status_next;
    data_t  out_d1_reg, out_d1_next;
    data_t  out_d2_reg, out_d2_next;

    logic   emit;
    byte_t  emit_status;
    data_t  emit_d1;
    data_t  emit_d2;
    count_t have_inc;
    logic   slot_free;

    assign have_inc  = have_reg + 2'd1;
    assign slot_free = !out_valid_reg || msg_out.ready;

    always_comb
    begin
        rs_next     = rs_reg;
        first_next  = first_reg;
        have_next   = have_reg;
        need_next   = need_reg;
        sysex_next  = sysex_reg;
        emit        = 1'b0;
        emit_status = q_data.value;
        emit_d1     = '0;
        emit_d2     = '0;
        case (q_data.kind)
            KIND_RT_FWD:
            begin
                emit = 1'b1;
            end
            KIND_SYX_START:
            begin
                sysex_next = 1'b1;
            end
            KIND_SYX_END:
            begin
                sysex_next = 1'b0;
            end
            KIND_SYS_COMMON:
            begin
                rs_next   = STATUS_NONE;
                have_next = '0;
                need_next = '0;
            end
            KIND_CHAN:
            begin
                rs_next   = q_data.value;
                need_next = q_data.need;
                have_next = '0;
            end
            KIND_DATA:
            begin
                if (!sysex_reg && (rs_reg != STATUS_NONE))
                begin
                    if (have_reg == '0)
                        first_next = q_data.value[DATA_W-1:0];
                    have_next = have_inc;
                    if (have_inc >= need_reg)
                    begin
                        emit        = 1'b1;
                        emit_status = rs_reg;
                        emit_d1     = (have_reg == '0) ? q_data.value[DATA_W-1:0] : first_reg;
                        emit_d2     = (need_reg == 2'd2) ? q_data.value[DATA_W-1:0] : '0;
                        have_next   = '0;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // a request that makes a message waits until the result register frees up
    assign q_pop = !q_empty && (!emit || slot_free);

    always_comb
    begin
        out_valid_next  = out_valid_reg && !msg_out.ready;
        out_status_next = out_status_reg;
        out_d1_next     = out_d1_reg;
        out_d2_next     = out_d2_reg;
        if (q_pop && emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = emit_status;
            out_d1_next     = emit_d1;
            out_d2_next     = emit_d2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg        <= STATUS_NONE;
            first_reg     <= '0;
            have_reg      <= '0;
            need_reg      <= '0;
            sysex_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                rs_reg    <= rs_next;
                first_reg <= first_next;
                have_reg  <= have_next;
                need_reg  <= need_next;
                sysex_reg <= sysex_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_d1_reg     <= out_d1_next;
        out_d2_reg     <= out_d2_next;
    end

    assign msg_out.valid      = out_valid_reg;
    assign msg_out.msg_status = out_status_reg;
    assign msg_out.msg_data1  = out_d1_reg;
    assign msg_out.msg_data2  = out_d2_reg;

    `MBSP_ASSERT_NOW(a_back_need_set, rs_reg != STATUS_NONE, need_reg != '0, "running status without length")
    `MBSP_ASSERT_NOW(a_back_have_below_need, rs_reg != STATUS_NONE, have_reg < need_reg, "partial count overran length")
    `MBSP_ASSERT_NEXT(a_back_emit_lands, q_pop && emit, out_valid_reg, "message lost at result register")

endmodule
